### hdl/sqaqm_pkg.sv
// Shared types, codes and constants of the shadow queue AQM marker.
// No dependencies; every other file of the block imports this package.
package sqaqm_pkg;

  localparam int PROB_BITS  = 16;
  localparam int COUNT_BITS = 12;
  localparam int WORD_W     = 32;
  localparam int AVG_W      = WORD_W + PROB_BITS;
  localparam int WGT_W      = PROB_BITS + 1;
  localparam int PROD_W     = WORD_W + WGT_W;
  localparam int ACC_W      = AVG_W + 1;
  localparam int PKT_W      = 16;
  localparam int MEAN_W     = 16;
  localparam int VERD_W     = 3;
  localparam int DIV_CNT_W  = $clog2(PROB_BITS);

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - COUNT_BITS - PROB_BITS;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [WGT_W-1:0] ONE_Q = WGT_W'(1) << PROB_BITS;

  localparam logic [WGT_W-1:0]      ALPHA_RST  = WGT_W'(16384);
  localparam logic [WGT_W-1:0]      MAXP_RST   = WGT_W'(58982);
  localparam logic [WORD_W-1:0]     WINDOW_RST = WORD_W'(187500);
  localparam logic [MEAN_W-1:0]     MEAN_RST   = MEAN_W'(1000);
  localparam logic [COUNT_BITS-1:0] LIMIT_RST  = COUNT_BITS'(100);

  typedef enum logic [1:0] {
    FUNC_ARRIVE = 2'd0,
    FUNC_DEPART = 2'd1,
    FUNC_TICK   = 2'd2
  } func_e;

  typedef enum logic [VERD_W-1:0] {
    V_ENQ        = 3'd0,
    V_MARK       = 3'd1,
    V_FORCE_DROP = 3'd2,
    V_EARLY_DROP = 3'd3,
    V_DEPART     = 3'd4,
    V_EMPTY      = 3'd5,
    V_TICK       = 3'd6
  } verdict_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ALPHA  = 3'd0,
    REG_MAXP   = 3'd1,
    REG_WINDOW = 3'd2,
    REG_MEAN   = 3'd3,
    REG_LIMIT  = 3'd4,
    REG_ECN    = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    MA_QUEUED   = 2'd0,
    MA_AVG_HI   = 2'd1,
    MA_AVG_LO   = 2'd2,
    MA_INTERVAL = 2'd3
  } mula_e;

  typedef enum logic [1:0] {
    MB_MEAN      = 2'd0,
    MB_ONE_MIN_A = 2'd1,
    MB_ALPHA     = 2'd2,
    MB_MAXP      = 2'd3
  } mulb_e;

  typedef enum logic [1:0] {
    ACC_HOLD    = 2'd0,
    ACC_CLR     = 2'd1,
    ACC_ADD     = 2'd2,
    ACC_ADD_SHR = 2'd3
  } acc_e;

  typedef struct packed {
    logic [WGT_W-1:0]      alpha;
    logic [WGT_W-1:0]      max_prob;
    logic [WORD_W-1:0]     window;
    logic [MEAN_W-1:0]     mean;
    logic [COUNT_BITS-1:0] limit;
    logic                  ecn;
  } cfg_t;

  typedef struct packed {
    logic  load;
    logic  event_en;
    mula_e mula;
    mulb_e mulb;
    acc_e  acc_op;
    logic  int_add_prod;
    logic  avg_load;
    logic  div_start;
    logic  prob_load;
    logic  push;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  typedef struct packed {
    verdict_e              verdict;
    logic [PROB_BITS-1:0]  prob;
    logic [COUNT_BITS-1:0] queued;
  } res_t;

endpackage

### hdl/sqaqm_div.sv
// Restoring divider for the marking probability, one quotient bit per cycle.
// Depends on sqaqm_pkg; a quotient that would not fit saturates at once.
module sqaqm_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [sqaqm_pkg::AVG_W-1:0]    num_i,
  input  logic [sqaqm_pkg::WORD_W-1:0]   den_i,
  output logic                           done_o,
  output logic [sqaqm_pkg::PROB_BITS-1:0] quo_o
);
  import sqaqm_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [WORD_W-1:0]    rem_q, rem_d;
  logic [WORD_W-1:0]    den_q, den_d;
  logic [PROB_BITS-1:0] low_q, low_d;
  logic [PROB_BITS-1:0] quo_q, quo_d;

  logic [WORD_W-1:0] den_eff;
  logic [WORD_W-1:0] num_hi;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              fits;

  assign den_eff = (den_i == '0) ? WORD_W'(1) : den_i;
  assign num_hi  = num_i[AVG_W-1:PROB_BITS];
  assign trial   = {rem_q, low_q[PROB_BITS-1]};
  assign diff    = trial - {1'b0, den_q};
  assign fits    = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quo_d  = quo_q;
    if (start_i) begin
      den_d = den_eff;
      // The high half at or above the divisor means the quotient needs more bits.
      if (num_hi >= den_eff) begin
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        rem_d  = num_hi;
        low_d  = num_i[PROB_BITS-1:0];
        cnt_d  = DIV_CNT_W'(PROB_BITS - 1);
        quo_d  = '0;
      end
    end else if (busy_q) begin
      rem_d = fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      low_d = low_q << 1;
      quo_d = {quo_q[PROB_BITS-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hdl/sqaqm_dp.sv
// Datapath: queue state, interval counter, EWMA average, shared multiplier,
// accumulator and the probability divider. Depends on sqaqm_pkg, sqaqm_div.
module sqaqm_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sqaqm_pkg::cmd_t              cmd_i,
  input  sqaqm_pkg::cfg_t              cfg_i,
  input  logic [1:0]                   in_func_i,
  input  logic [sqaqm_pkg::PKT_W-1:0]  in_bytes_i,
  input  logic [sqaqm_pkg::PROB_BITS-1:0] in_rand_i,
  input  logic                         in_cap_i,
  output sqaqm_pkg::sts_t              sts_o,
  output sqaqm_pkg::res_t              res_o
);
  import sqaqm_pkg::*;

  // Latched event.
  func_e                func_q;
  logic [PKT_W-1:0]     bytes_q;
  logic [PROB_BITS-1:0] rand_q;
  logic                 cap_q;

  // Block state.
  logic [COUNT_BITS-1:0] queued_q, queued_d;
  logic [WORD_W-1:0]     interval_q, interval_d;
  logic [AVG_W-1:0]      avg_q, avg_d;
  logic [PROB_BITS-1:0]  prob_q, prob_d;
  verdict_e              verdict_q, verdict_d;

  // Arithmetic.
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [WORD_W-1:0] mul_a;
  logic [WGT_W-1:0]  mul_b;
  logic [WGT_W-1:0]  alpha_c, one_min_a, maxp_c;
  logic [WORD_W-1:0] add_val;
  logic [WORD_W:0]   sum;
  logic [WORD_W-1:0] sat_sum;
  logic              div_done;
  logic [PROB_BITS-1:0] quo;
  logic              mark, ecn_mark;

  assign alpha_c   = (cfg_i.alpha > ONE_Q) ? ONE_Q : cfg_i.alpha;
  assign maxp_c    = (cfg_i.max_prob > ONE_Q) ? ONE_Q : cfg_i.max_prob;
  assign one_min_a = ONE_Q - alpha_c;

  always_comb begin
    case (cmd_i.mula)
      MA_QUEUED:   mul_a = WORD_W'(queued_q);
      MA_AVG_HI:   mul_a = avg_q[AVG_W-1:PROB_BITS];
      MA_AVG_LO:   mul_a = WORD_W'(avg_q[PROB_BITS-1:0]);
      MA_INTERVAL: mul_a = interval_q;
      default:     mul_a = '0;
    endcase
    case (cmd_i.mulb)
      MB_MEAN:      mul_b = WGT_W'(cfg_i.mean);
      MB_ONE_MIN_A: mul_b = one_min_a;
      MB_ALPHA:     mul_b = alpha_c;
      MB_MAXP:      mul_b = maxp_c;
      default:      mul_b = '0;
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    case (cmd_i.acc_op)
      ACC_HOLD:    acc_d = acc_q;
      ACC_CLR:     acc_d = '0;
      ACC_ADD:     acc_d = acc_q + ACC_W'(prod_q);
      ACC_ADD_SHR: acc_d = acc_q + ACC_W'(prod_q >> PROB_BITS);
      default:     acc_d = acc_q;
    endcase
  end

  // Saturating add into the interval counter: packet bytes or the backlog product.
  assign add_val = cmd_i.int_add_prod ? prod_q[WORD_W-1:0] : WORD_W'(bytes_q);
  assign sum     = {1'b0, interval_q} + {1'b0, add_val};
  assign sat_sum = sum[WORD_W] ? '1 : sum[WORD_W-1:0];

  assign mark     = (rand_q < prob_q);
  assign ecn_mark = cfg_i.ecn & cap_q;

  always_comb begin
    queued_d   = queued_q;
    interval_d = interval_q;
    avg_d      = avg_q;
    prob_d     = prob_q;
    verdict_d  = verdict_q;
    if (cmd_i.event_en) begin
      case (func_q)
        FUNC_ARRIVE: begin
          if (queued_q >= cfg_i.limit) begin
            verdict_d = V_FORCE_DROP;
          end else begin
            interval_d = sat_sum;
            if (mark) begin
              verdict_d = ecn_mark ? V_MARK : V_EARLY_DROP;
            end else begin
              verdict_d = V_ENQ;
            end
            // An early drop leaves the count alone; the count itself never wraps.
            if ((!mark || ecn_mark) && (queued_q != '1)) begin
              queued_d = queued_q + COUNT_BITS'(1);
            end
          end
        end
        FUNC_DEPART: begin
          if (queued_q != '0) begin
            queued_d  = queued_q - COUNT_BITS'(1);
            verdict_d = V_DEPART;
          end else begin
            verdict_d = V_EMPTY;
          end
        end
        default: begin
          verdict_d = verdict_q;
        end
      endcase
    end
    if (cmd_i.int_add_prod) begin
      interval_d = sat_sum;
    end
    if (cmd_i.avg_load) begin
      avg_d      = acc_q[AVG_W-1:0];
      interval_d = '0;
    end
    if (cmd_i.prob_load) begin
      prob_d    = quo;
      verdict_d = V_TICK;
    end
  end

  sqaqm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (acc_q[AVG_W-1:0]),
    .den_i   (cfg_i.window),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queued_q   <= '0;
      interval_q <= '0;
      avg_q      <= '0;
      prob_q     <= '0;
      verdict_q  <= V_ENQ;
    end else begin
      queued_q   <= queued_d;
      interval_q <= interval_d;
      avg_q      <= avg_d;
      prob_q     <= prob_d;
      verdict_q  <= verdict_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.load) begin
      func_q  <= func_e'(in_func_i);
      bytes_q <= in_bytes_i;
      rand_q  <= in_rand_i;
      cap_q   <= in_cap_i;
    end
  end

  assign sts_o.div_done = div_done;
  assign res_o.verdict  = verdict_q;
  assign res_o.prob     = prob_q;
  assign res_o.queued   = queued_q;

endmodule

### hdl/sqaqm_ctrl.sv
// Controller: sequences arrival, departure and tick events over the datapath.
// Depends on sqaqm_pkg; drives the datapath through the command struct.
module sqaqm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [1:0]       in_func_i,
  input  logic             out_free_i,
  input  sqaqm_pkg::sts_t  sts_i,
  output logic             in_ready_o,
  output sqaqm_pkg::cmd_t  cmd_o
);
  import sqaqm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVENT,
    S_T_QM,
    S_T_SAT,
    S_T_AHI,
    S_T_ALO,
    S_T_INT,
    S_T_AVG,
    S_T_PHI,
    S_T_PLO,
    S_T_PSUM,
    S_T_DIV0,
    S_T_DIVW,
    S_PUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_func_i) inside
            FUNC_ARRIVE, FUNC_DEPART: state_d = S_EVENT;
            FUNC_TICK:                state_d = S_T_QM;
            default:                  state_d = S_IDLE;
          endcase
        end
      end
      S_EVENT:  state_d = S_PUSH;
      S_T_QM:   state_d = S_T_SAT;
      S_T_SAT:  state_d = S_T_AHI;
      S_T_AHI:  state_d = S_T_ALO;
      S_T_ALO:  state_d = S_T_INT;
      S_T_INT:  state_d = S_T_AVG;
      S_T_AVG:  state_d = S_T_PHI;
      S_T_PHI:  state_d = S_T_PLO;
      S_T_PLO:  state_d = S_T_PSUM;
      S_T_PSUM: state_d = S_T_DIV0;
      S_T_DIV0: state_d = S_T_DIVW;
      S_T_DIVW: state_d = sts_i.div_done ? S_PUSH : S_T_DIVW;
      S_PUSH:   state_d = out_free_i ? S_IDLE : S_PUSH;
      default:  state_d = S_IDLE;
    endcase
  end

  // The multiplier registers its product, so each add uses the product
  // selected one state earlier.
  always_comb begin
    cmd_o              = '0;
    cmd_o.mula         = MA_QUEUED;
    cmd_o.mulb         = MB_MEAN;
    cmd_o.acc_op       = ACC_HOLD;
    unique case (state_q)
      S_IDLE:   cmd_o.load = in_valid_i;
      S_EVENT:  cmd_o.event_en = 1'b1;
      S_T_QM: begin
        cmd_o.mula = MA_QUEUED;
        cmd_o.mulb = MB_MEAN;
      end
      S_T_SAT: begin
        cmd_o.int_add_prod = 1'b1;
        cmd_o.mula         = MA_AVG_HI;
        cmd_o.mulb         = MB_ONE_MIN_A;
        cmd_o.acc_op       = ACC_CLR;
      end
      S_T_AHI: begin
        cmd_o.acc_op = ACC_ADD;
        cmd_o.mula   = MA_AVG_LO;
        cmd_o.mulb   = MB_ONE_MIN_A;
      end
      S_T_ALO: begin
        cmd_o.acc_op = ACC_ADD_SHR;
        cmd_o.mula   = MA_INTERVAL;
        cmd_o.mulb   = MB_ALPHA;
      end
      S_T_INT:  cmd_o.acc_op = ACC_ADD;
      S_T_AVG: begin
        cmd_o.avg_load = 1'b1;
        cmd_o.acc_op   = ACC_CLR;
      end
      S_T_PHI: begin
        cmd_o.mula = MA_AVG_HI;
        cmd_o.mulb = MB_MAXP;
      end
      S_T_PLO: begin
        cmd_o.acc_op = ACC_ADD;
        cmd_o.mula   = MA_AVG_LO;
        cmd_o.mulb   = MB_MAXP;
      end
      S_T_PSUM: cmd_o.acc_op = ACC_ADD_SHR;
      S_T_DIV0: cmd_o.div_start = 1'b1;
      S_T_DIVW: cmd_o.prob_load = sts_i.div_done;
      S_PUSH:   cmd_o.push = out_free_i;
      default:  cmd_o.load = 1'b0;
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/shadow_queue_aqm_marker_core.sv
// Shadow queue AQM marker: configuration registers, result register, controller, datapath.
// Arrival, departure: beat latched in S_IDLE, verdict registered in S_EVENT, pushed out in S_PUSH.
// Tick: S_T_QM..S_T_PSUM form the new average and the numerator, then the 16-step divider runs.
// A pending result sits in the output register while the next beat is worked on.
// Reset (rst_ni, async, active low) clears the queue state and loads register defaults.
// Depends on sqaqm_pkg, sqaqm_ctrl, sqaqm_dp.
module shadow_queue_aqm_marker_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [sqaqm_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // pkt_bytes[15:0], rand_q16[31:16]
  input  logic [sqaqm_pkg::IN_USER_W-1:0]     s_axis_tuser,  // func[1:0], ecn_capable[2]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [sqaqm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // prob_now_q16[15:0], queued_now[27:16]
  output logic [sqaqm_pkg::VERD_W-1:0]        m_axis_tuser,  // verdict[2:0]
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sqaqm_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [sqaqm_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import sqaqm_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  sts_t sts;
  res_t res;
  res_t out_res_q;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_ALPHA:  cfg_d.alpha    = cfg_data_i[WGT_W-1:0];
        REG_MAXP:   cfg_d.max_prob = cfg_data_i[WGT_W-1:0];
        REG_WINDOW: cfg_d.window   = cfg_data_i[WORD_W-1:0];
        REG_MEAN:   cfg_d.mean     = cfg_data_i[MEAN_W-1:0];
        REG_LIMIT:  cfg_d.limit    = cfg_data_i[COUNT_BITS-1:0];
        REG_ECN:    cfg_d.ecn      = cfg_data_i[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  assign out_free    = !out_valid_q || m_axis_tready;
  assign out_valid_d = cmd.push ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha    <= ALPHA_RST;
      cfg_q.max_prob <= MAXP_RST;
      cfg_q.window   <= WINDOW_RST;
      cfg_q.mean     <= MEAN_RST;
      cfg_q.limit    <= LIMIT_RST;
      cfg_q.ecn      <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.push) begin
      out_res_q <= res;
    end
  end

  sqaqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser[1:0]),
    .out_free_i (out_free),
    .sts_i      (sts),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  sqaqm_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg_q),
    .in_func_i  (s_axis_tuser[1:0]),
    .in_bytes_i (s_axis_tdata[PKT_W-1:0]),
    .in_rand_i  (s_axis_tdata[PKT_W+PROB_BITS-1:PKT_W]),
    .in_cap_i   (s_axis_tuser[2]),
    .sts_o      (sts),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_res_q.queued, out_res_q.prob};
  assign m_axis_tuser  = out_res_q.verdict;

endmodule
